@@ hw/rtl/dqs_pkg.sv @@
package dqs_pkg;

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int KIND_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_REM_HEAD = 3'd2,
    CMD_REM_TAIL = 3'd3,
    CMD_SEARCH   = 3'd4,
    CMD_DUMP     = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DONE      = 3'd0,
    KIND_FOUND     = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_EMPTY     = 3'd3,
    KIND_ELEMENT   = 3'd4,
    KIND_FULL      = 3'd5
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic  latch;
    logic  wr_head;
    logic  wr_tail;
    logic  pop_head;
    logic  pop_tail;
    logic  rd_start;
    logic  rd_next;
    logic  set_kind;
    kind_t kind;
    logic  load_status;
    logic  load_elem;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             match;
    logic             at_last;
    logic             out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/dqs_if.sv @@
interface dqs_in_if;
  logic                             valid;
  logic                             ready;
  logic [dqs_pkg::CMD_W-1:0]        cmd;
  logic signed [dqs_pkg::VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dqs_out_if;
  logic                             valid;
  logic                             ready;
  logic [dqs_pkg::KIND_W-1:0]       kind;
  logic signed [dqs_pkg::VAL_W-1:0] element;
  logic                             last;

  modport source (output valid, output kind, output element, output last, input ready);
  modport sink   (input valid, input kind, input element, input last, output ready);
endinterface

@@ hw/rtl/dqs_ram.sv @@
module dqs_ram #(
  parameter int W = 32,
  parameter int D = 32,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/dqs_ctrl.sv @@
module dqs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dqs_pkg::dp_stat_t  stat,
  output dqs_pkg::dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_REPLY  = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_DUMP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = dqs_pkg::KIND_DONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (dqs_pkg::cmd_t'(stat.cmd))
          dqs_pkg::CMD_INS_HEAD, dqs_pkg::CMD_INS_TAIL: begin
            cmd.set_kind = 1'b1;
            if (stat.full) begin
              cmd.kind = dqs_pkg::KIND_FULL;
            end else begin
              cmd.kind    = dqs_pkg::KIND_DONE;
              cmd.wr_head = (stat.cmd == dqs_pkg::CMD_INS_HEAD);
              cmd.wr_tail = (stat.cmd == dqs_pkg::CMD_INS_TAIL);
            end
            state_nxt = ST_REPLY;
          end
          dqs_pkg::CMD_REM_HEAD, dqs_pkg::CMD_REM_TAIL: begin
            cmd.set_kind = 1'b1;
            if (stat.empty) begin
              cmd.kind = dqs_pkg::KIND_EMPTY;
            end else begin
              cmd.kind     = dqs_pkg::KIND_DONE;
              cmd.pop_head = (stat.cmd == dqs_pkg::CMD_REM_HEAD);
              cmd.pop_tail = (stat.cmd == dqs_pkg::CMD_REM_TAIL);
            end
            state_nxt = ST_REPLY;
          end
          dqs_pkg::CMD_SEARCH, dqs_pkg::CMD_DUMP: begin
            if (stat.empty) begin
              cmd.set_kind = 1'b1;
              cmd.kind     = dqs_pkg::KIND_EMPTY;
              state_nxt    = ST_REPLY;
            end else begin
              cmd.rd_start = 1'b1;
              state_nxt    = (stat.cmd == dqs_pkg::CMD_SEARCH) ? ST_SCAN : ST_DUMP;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (stat.match) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = dqs_pkg::KIND_FOUND;
          state_nxt    = ST_REPLY;
        end else if (stat.at_last) begin
          cmd.set_kind = 1'b1;
          cmd.kind     = dqs_pkg::KIND_NOT_FOUND;
          state_nxt    = ST_REPLY;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      ST_DUMP: begin
        if (stat.out_free) begin
          cmd.load_elem = 1'b1;
          if (stat.at_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_REPLY: begin
        if (stat.out_free) begin
          cmd.load_status = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/dqs_dp.sv @@
module dqs_dp #(
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [dqs_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [dqs_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dqs_pkg::KIND_W-1:0]       out_kind,
  output logic signed [dqs_pkg::VAL_W-1:0] out_element,
  output logic                             out_last,
  input  dqs_pkg::dp_cmd_t                 cmd,
  output dqs_pkg::dp_stat_t                stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [dqs_pkg::CMD_W-1:0]  cmd_r;
  logic [dqs_pkg::VAL_W-1:0]  val_r;
  logic [dqs_pkg::KIND_W-1:0] kind_r;
  logic [PW-1:0]              front_r, rpos_r, idx_r;
  logic [CW-1:0]              occ_r;
  logic                       out_valid_r, out_last_r;
  logic [dqs_pkg::KIND_W-1:0] out_kind_r;
  logic [dqs_pkg::VAL_W-1:0]  out_elem_r;

  logic [PW-1:0]             front_dec, front_inc, rpos_inc, tail_pos;
  logic [SW-1:0]             tail_sum;
  logic                      ram_we, ram_re;
  logic [PW-1:0]             ram_waddr, ram_raddr;
  logic [dqs_pkg::VAL_W-1:0] ram_rdata;
  logic                      out_free, at_last;

  assign front_dec = (front_r == '0) ? PW'(DEPTH - 1) : front_r - PW'(1);
  assign front_inc = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + PW'(1);
  assign rpos_inc  = (rpos_r == PW'(DEPTH - 1)) ? '0 : rpos_r + PW'(1);
  assign tail_sum  = SW'(front_r) + SW'(occ_r);
  assign tail_pos  = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);

  assign ram_we    = cmd.wr_head | cmd.wr_tail;
  assign ram_waddr = cmd.wr_head ? front_dec : tail_pos;
  assign ram_re    = cmd.rd_start | cmd.rd_next;
  assign ram_raddr = cmd.rd_start ? front_r : rpos_inc;

  dqs_ram #(
    .W (dqs_pkg::VAL_W),
    .D (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign at_last  = (CW'(idx_r) == occ_r - CW'(1));

  assign stat.cmd      = cmd_r;
  assign stat.empty    = (occ_r == '0);
  assign stat.full     = (occ_r == CW'(DEPTH));
  assign stat.match    = (ram_rdata == val_r);
  assign stat.at_last  = at_last;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_head) begin
        front_r <= front_dec;
      end else if (cmd.pop_head) begin
        front_r <= front_inc;
      end
      if (cmd.wr_head || cmd.wr_tail) begin
        occ_r <= occ_r + CW'(1);
      end else if (cmd.pop_head || cmd.pop_tail) begin
        occ_r <= occ_r - CW'(1);
      end
      if (cmd.load_status || cmd.load_elem) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      val_r <= in_value;
    end
    if (cmd.set_kind) begin
      kind_r <= cmd.kind;
    end
    if (cmd.rd_start) begin
      idx_r  <= '0;
      rpos_r <= front_r;
    end else if (cmd.rd_next) begin
      idx_r  <= idx_r + PW'(1);
      rpos_r <= rpos_inc;
    end
    if (cmd.load_status) begin
      out_kind_r <= kind_r;
      out_elem_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.load_elem) begin
      out_kind_r <= dqs_pkg::KIND_ELEMENT;
      out_elem_r <= ram_rdata;
      out_last_r <= at_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_element = out_elem_r;
  assign out_last    = out_last_r;

endmodule

@@ hw/rtl/deque_with_search.sv @@
// Bounded double-ended queue of signed 32-bit words in a ring of DEPTH RAM
// entries. A push or pop passes through the decode and reply states before
// its result word is loaded into the output register; a search checks one
// stored entry per cycle; a dump streams one element word per cycle while
// the output is free, paced by the RAM's single registered read port. A push
// onto a full queue is dropped and answered full; a pop, search or dump of an
// empty queue is answered empty. Commands 6 and 7 are ignored. No clearing
// pass is needed after reset. A new command is taken once the previous one
// has placed its last result word, even if that word is still waiting.
module deque_with_search #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  dqs_in_if.sink    in_ch,
  dqs_out_if.source out_ch
);

  dqs_pkg::dp_cmd_t  cmd;
  dqs_pkg::dp_stat_t stat;
  logic              in_ready;

  dqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (in_ch.cmd),
    .in_value    (in_ch.value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_element (out_ch.element),
    .out_last    (out_ch.last),
    .cmd         (cmd),
    .stat        (stat)
  );

  assign in_ch.ready = in_ready;

endmodule
